// File: src/task_wait_queue_top_defines.svh
// Assertion macros shared by the wait queue RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef TASK_WAIT_QUEUE_TOP_DEFINES_SVH
`define TASK_WAIT_QUEUE_TOP_DEFINES_SVH

// Concurrent assertion that is switched off while the asynchronous reset is held.
`define TWQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that must hold at every clock edge, reset included.
`define TWQ_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/twq_pkg.sv
// Package for the task wait queue: operation codes and the command and status
// structs that join the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package twq_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_DEQUEUE  = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_CONTAINS = 2'd3
  } op_e;

  // Address source for a read of the link memory.
  typedef enum logic [1:0] {
    LRD_ID,
    LRD_FIRST,
    LRD_NEXT
  } link_rd_e;

  typedef enum logic [1:0] {
    LW_NONE,
    LW_ID_ZERO,
    LW_LAST_ID,
    LW_PREV_SUCC
  } link_wr_e;

  typedef enum logic [2:0] {
    FW_NONE,
    FW_CLEAR,
    FW_SET_ID,
    FW_CLR_ID,
    FW_CLR_FIRST
  } flag_wr_e;

  typedef enum logic [1:0] {
    FU_HOLD,
    FU_ID,
    FU_NEXT
  } first_upd_e;

  typedef enum logic [1:0] {
    LU_HOLD,
    LU_ID,
    LU_PREV
  } last_upd_e;

  typedef enum logic [1:0] {
    NE_HOLD,
    NE_SET,
    NE_CLR
  } ne_upd_e;

  typedef enum logic [1:0] {
    PV_HOLD,
    PV_FIRST,
    PV_NEXT
  } prev_upd_e;

  typedef struct packed {
    logic       load_in;
    logic       flag_re;
    logic       link_re;
    link_rd_e   link_rd;
    link_wr_e   link_wr;
    flag_wr_e   flag_wr;
    first_upd_e first_upd;
    last_upd_e  last_upd;
    ne_upd_e    ne_upd;
    prev_upd_e  prev_upd;
    logic       save_succ;
    logic       set_ok;
    logic       set_taken;
    logic       out_load;
  } twq_cmd_t;

  typedef struct packed {
    op_e  op;
    logic id_ok;
    logic flag_hit;
    logic nonempty;
    logic first_eq_id;
    logic last_eq_id;
    logic first_eq_last;
    logic next_eq_id;
    logic prev_eq_last;
    logic clr_done;
    logic out_free;
  } twq_sts_t;

endpackage

// File: src/twq_datapath.sv
// Datapath of the task wait queue: link and membership memories, head and tail
// pointers, walk registers and the output register. Depends on twq_pkg.
`timescale 1ns / 1ps

module twq_datapath #(
  parameter int NUM_TASKS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       func_i,
  input  logic [5:0]       task_id_i,
  input  twq_pkg::twq_cmd_t cmd_i,
  output twq_pkg::twq_sts_t sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             done_ok_o,
  output logic [5:0]       task_out_o,
  output logic             now_empty_o
);
  import twq_pkg::*;

  localparam int PTR_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW    = (PTR_W + 1 > 6) ? PTR_W + 1 : 6;

  logic [PTR_W-1:0] link_mem [NUM_TASKS];
  logic             flag_mem [NUM_TASKS];

  logic [PTR_W-1:0] link_rd_q;
  logic             flag_rd_q;

  op_e              func_q;
  logic [5:0]       id_q;
  logic [PTR_W-1:0] prev_q, prev_d;
  logic [PTR_W-1:0] succ_q;
  logic             ok_q;
  logic [PTR_W-1:0] taken_q;

  logic [PTR_W-1:0] first_q, first_d;
  logic [PTR_W-1:0] last_q, last_d;
  logic             ne_q, ne_d;
  logic [PTR_W-1:0] clr_cnt_q;
  logic             out_valid_q, out_valid_d;

  logic             out_ok_q;
  logic [5:0]       out_task_q;
  logic             out_empty_q;

  logic [CW-1:0]    id_ext;
  logic [CW-1:0]    taken_ext;
  logic [PTR_W-1:0] id_idx;
  logic             id_ok;

  logic             link_we;
  logic [PTR_W-1:0] link_waddr;
  logic [PTR_W-1:0] link_wdata;
  logic [PTR_W-1:0] link_raddr;
  logic             flag_we;
  logic [PTR_W-1:0] flag_waddr;
  logic             flag_wdata;

  assign id_ext    = CW'(id_q);
  assign id_idx    = id_ext[PTR_W-1:0];
  assign id_ok     = (id_ext < CW'(NUM_TASKS));
  assign taken_ext = CW'(taken_q);

  // Memory port selection.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = id_idx;
    link_wdata = '0;
    case (cmd_i.link_wr)
      LW_ID_ZERO: begin
        link_we = 1'b1;
      end
      LW_LAST_ID: begin
        link_we    = 1'b1;
        link_waddr = last_q;
        link_wdata = id_idx;
      end
      LW_PREV_SUCC: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = succ_q;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase

    case (cmd_i.link_rd)
      LRD_FIRST: link_raddr = first_q;
      LRD_NEXT:  link_raddr = link_rd_q;
      default:   link_raddr = id_idx;
    endcase

    flag_we    = 1'b0;
    flag_waddr = id_idx;
    flag_wdata = 1'b0;
    case (cmd_i.flag_wr)
      FW_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_cnt_q;
      end
      FW_SET_ID: begin
        flag_we    = 1'b1;
        flag_wdata = 1'b1;
      end
      FW_CLR_ID: begin
        flag_we = 1'b1;
      end
      FW_CLR_FIRST: begin
        flag_we    = 1'b1;
        flag_waddr = first_q;
      end
      default: begin
        flag_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd_i.link_re) begin
      link_rd_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (cmd_i.flag_re) begin
      flag_rd_q <= flag_mem[id_idx];
    end
  end

  // Queue pointer updates.
  always_comb begin
    case (cmd_i.first_upd)
      FU_ID:   first_d = id_idx;
      FU_NEXT: first_d = link_rd_q;
      default: first_d = first_q;
    endcase
    case (cmd_i.last_upd)
      LU_ID:   last_d = id_idx;
      LU_PREV: last_d = prev_q;
      default: last_d = last_q;
    endcase
    case (cmd_i.ne_upd)
      NE_SET:  ne_d = 1'b1;
      NE_CLR:  ne_d = 1'b0;
      default: ne_d = ne_q;
    endcase
    case (cmd_i.prev_upd)
      PV_FIRST: prev_d = first_q;
      PV_NEXT:  prev_d = link_rd_q;
      default:  prev_d = prev_q;
    endcase
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      last_q      <= '0;
      ne_q        <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      last_q      <= last_d;
      ne_q        <= ne_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.flag_wr == FW_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Transaction payload and per-item working registers.
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    if (cmd_i.load_in) begin
      func_q  <= op_e'(func_i);
      id_q    <= task_id_i;
      ok_q    <= 1'b0;
      taken_q <= '0;
    end else begin
      if (cmd_i.set_ok) begin
        ok_q <= 1'b1;
      end
      if (cmd_i.set_taken) begin
        taken_q <= first_q;
      end
    end
    if (cmd_i.save_succ) begin
      succ_q <= link_rd_q;
    end
    if (cmd_i.out_load) begin
      out_ok_q    <= ok_q;
      out_task_q  <= taken_ext[5:0];
      out_empty_q <= ~ne_q;
    end
  end

  always_comb begin
    sts_o.op            = func_q;
    sts_o.id_ok         = id_ok;
    sts_o.flag_hit      = flag_rd_q;
    sts_o.nonempty      = ne_q;
    sts_o.first_eq_id   = (first_q == id_idx);
    sts_o.last_eq_id    = (last_q == id_idx);
    sts_o.first_eq_last = (first_q == last_q);
    sts_o.next_eq_id    = (link_rd_q == id_idx);
    sts_o.prev_eq_last  = (prev_q == last_q);
    sts_o.clr_done      = (clr_cnt_q == PTR_W'(NUM_TASKS - 1));
    sts_o.out_free      = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign done_ok_o   = out_ok_q;
  assign task_out_o  = out_task_q;
  assign now_empty_o = out_empty_q;

endmodule

// File: src/twq_ctrl.sv
// Controller of the task wait queue: sequences the clearing pass, the lookup,
// the list walk and the result hand-off. Depends on twq_pkg and the macro header.
`timescale 1ns / 1ps
`include "task_wait_queue_top_defines.svh"

module twq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  twq_pkg::twq_sts_t sts_i,
  output twq_pkg::twq_cmd_t cmd_o
);
  import twq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_ENQ_LINK,
    S_WALK,
    S_OUT
  } state_e;

  state_e   state_q, state_d;
  twq_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd.flag_wr = FW_CLEAR;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.flag_re = 1'b1;
        cmd.link_re = 1'b1;
        cmd.link_rd = (sts_i.op == OP_DEQUEUE) ? LRD_FIRST : LRD_ID;
        state_d     = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_OUT;
        case (sts_i.op)
          OP_DEQUEUE: begin
            if (sts_i.nonempty) begin
              cmd.set_ok    = 1'b1;
              cmd.set_taken = 1'b1;
              cmd.flag_wr   = FW_CLR_FIRST;
              if (sts_i.first_eq_last) begin
                cmd.ne_upd = NE_CLR;
              end else begin
                cmd.first_upd = FU_NEXT;
              end
            end
          end
          OP_CONTAINS: begin
            cmd.set_ok = sts_i.id_ok & sts_i.flag_hit;
          end
          OP_ENQUEUE: begin
            if (sts_i.id_ok && !sts_i.flag_hit) begin
              cmd.set_ok  = 1'b1;
              cmd.link_wr = LW_ID_ZERO;
              cmd.flag_wr = FW_SET_ID;
              if (sts_i.nonempty) begin
                state_d = S_ENQ_LINK;
              end else begin
                cmd.first_upd = FU_ID;
                cmd.last_upd  = LU_ID;
                cmd.ne_upd    = NE_SET;
              end
            end
          end
          OP_REMOVE: begin
            if (sts_i.id_ok && sts_i.flag_hit && sts_i.nonempty) begin
              if (sts_i.first_eq_id) begin
                cmd.set_ok  = 1'b1;
                cmd.flag_wr = FW_CLR_ID;
                if (sts_i.last_eq_id) begin
                  cmd.ne_upd = NE_CLR;
                end else begin
                  cmd.first_upd = FU_NEXT;
                end
              end else begin
                cmd.save_succ = 1'b1;
                cmd.prev_upd  = PV_FIRST;
                cmd.link_re   = 1'b1;
                cmd.link_rd   = LRD_FIRST;
                state_d       = S_WALK;
              end
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_ENQ_LINK: begin
        cmd.link_wr  = LW_LAST_ID;
        cmd.last_upd = LU_ID;
        state_d      = S_OUT;
      end
      S_WALK: begin
        if (sts_i.next_eq_id) begin
          cmd.set_ok  = 1'b1;
          cmd.link_wr = LW_PREV_SUCC;
          cmd.flag_wr = FW_CLR_ID;
          if (sts_i.last_eq_id) begin
            cmd.last_upd = LU_PREV;
          end
          state_d = S_OUT;
        end else if (sts_i.prev_eq_last) begin
          state_d = S_OUT;
        end else begin
          cmd.prev_upd = PV_NEXT;
          cmd.link_re  = 1'b1;
          cmd.link_rd  = LRD_NEXT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  `TWQ_ASSERT_RST(a_accept_to_lookup, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_LOOKUP), "accepted transaction did not start a lookup")
  `TWQ_ASSERT_CLK(a_out_load_free, clk_i, cmd.out_load |-> sts_i.out_free, "result loaded over an unread result")
  `TWQ_ASSERT_RST(a_walk_nonempty, clk_i, rst_ni, (state_q == S_WALK) |-> sts_i.nonempty, "list walk on an empty queue")
  `TWQ_ASSERT_RST(a_clear_ends, clk_i, rst_ni, (state_q == S_CLEAR && sts_i.clr_done) |=> (state_q == S_IDLE), "clearing pass did not finish")

endmodule

// File: src/task_wait_queue_top.sv
// Top level of the task wait queue: joins the controller and the datapath.
// Depends on twq_pkg, twq_ctrl and twq_datapath.
`timescale 1ns / 1ps

// A FIFO wait queue of task identifiers, held as a singly linked list with one
// link entry and one membership flag per task. Each input transaction carries an
// operation (enqueue, dequeue, remove, contains) and a task id, and produces
// exactly one result transaction with the success flag, the task taken by a
// dequeue and whether the queue is empty afterwards. Items are handled one at a
// time, each through the lookup, decide and output states. An enqueue into a
// non-empty queue also links the new task behind the tail, and a remove of a
// task behind the head finds its predecessor by walking the list one link per
// cycle through the single read port of the link memory. A new transaction is
// taken as soon as the previous result has been placed in the output register,
// even while that result still waits to be taken. After reset the membership
// store is cleared one entry per cycle, so the block accepts no transaction
// until every entry has been cleared.
module task_wait_queue_top #(
  parameter int NUM_TASKS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [5:0] task_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       done_ok_o,
  output logic [5:0] task_out_o,
  output logic       now_empty_o
);
  import twq_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  twq_cmd_t cmd;
  twq_sts_t sts;

  twq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  twq_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (func_i),
    .task_id_i   (task_id_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .done_ok_o   (done_ok_o),
    .task_out_o  (task_out_o),
    .now_empty_o (now_empty_o)
  );

endmodule
